// ===== hw/rtl/sus_pkg.sv =====
// shared types, codes and compare functions for the sorted unique set
// no dependencies; imported by every module of the block
package sus_pkg;

    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 6;
    localparam int ACTION_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int POS_OUT_W   = 6;
    localparam int STATUS_W    = 3;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

    // what the back end has to do with a queued item
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_READ,
        OP_NOP,
        OP_NAN
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_CLEARED   = 3'd3,
        ST_READ_OK   = 3'd4,
        ST_RANGE     = 3'd5,
        ST_NAN       = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_SHIFT,
        BK_PUT,
        BK_READ,
        BK_RESULT
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] key;
        logic [INDEX_W-1:0] index;
    } cmd_t;

    // unsigned key that follows value order; both float zeros share a key
    function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v,
                                                      input logic is_float);
        logic [VALUE_W-1:0] t;
        t = (is_float && v == 32'h8000_0000) ? '0 : v;
        if (is_float && t[VALUE_W-1])
            return ~t;
        return t ^ 32'h8000_0000;
    endfunction

    function automatic logic is_nan_bits(input logic [VALUE_W-1:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != '0);
    endfunction

endpackage

// ===== hw/rtl/sus_front.sv =====
// front end: takes input transactions and classifies them into queue commands
// depends on sus_pkg
module sus_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sus_pkg::ACTION_W-1:0]   s_tuser,   // action
    input  logic [39:0]                    s_tdata,   // value[31:0], index[37:32]
    input  logic                           element_is_float,
    input  logic                           q_full,
    output logic                           q_push,
    output sus_pkg::cmd_t                  q_cmd
);
    import sus_pkg::*;

    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    op_t                op;

    assign value = s_tdata[VALUE_W-1:0];
    assign index = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];

    always_comb
    begin
        unique case (s_tuser)
            ACT_CLEAR:  op = OP_CLEAR;
            ACT_INSERT: op = (element_is_float && is_nan_bits(value)) ? OP_NAN : OP_INSERT;
            ACT_READ:   op = OP_READ;
            default:    op = OP_NOP;
        endcase
    end

    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && !q_full;
    assign q_cmd.op    = op;
    assign q_cmd.value = value;
    assign q_cmd.key   = order_key(value, element_is_float);
    assign q_cmd.index = index;

endmodule

// ===== hw/rtl/sus_fifo.sv =====
// two-entry command queue between front end and back end
// depends on sus_pkg
module sus_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sus_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output sus_pkg::cmd_t dout,
    output logic          not_empty
);
    import sus_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign dout      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== hw/rtl/sus_back.sv =====
// back end: element memory, scan/shift sequencer and output register
// depends on sus_pkg
module sus_back #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          element_is_float,
    input  logic                          cmd_valid,
    input  sus_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sus_pkg::STATUS_W-1:0]  m_tuser,   // status
    output logic [47:0]                   m_tdata    // element_count[6:0], element[38:7],
                                                     // position[44:39]
);
    import sus_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int OW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
    localparam int PW = (CW > POS_OUT_W) ? CW : POS_OUT_W;

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;

    back_state_t        state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    cmd_t               cur_reg, cur_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               have_reg, have_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [VALUE_W-1:0] prev_key_reg, prev_key_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      sh_rd_reg, sh_rd_next;
    logic [CW-1:0]      left_reg, left_next;
    logic               wr_pending_reg, wr_pending_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;
    status_t            res_status_reg, res_status_next;
    logic [VALUE_W-1:0] res_elem_reg, res_elem_next;
    logic [CW-1:0]      res_pos_reg, res_pos_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    status_t                m_status_reg, m_status_next;
    logic [COUNT_OUT_W-1:0] m_count_reg, m_count_next;
    logic [VALUE_W-1:0]     m_elem_reg, m_elem_next;
    logic [POS_OUT_W-1:0]   m_pos_reg, m_pos_next;

    logic [VALUE_W-1:0] elem_key;
    logic               hit;
    logic               scan_done;
    logic [CW-1:0]      found_pos;
    logic               dup;
    logic               full;
    logic [XW-1:0]      idx_x;
    logic               idx_ok;
    logic               res_free;
    logic [CW-1:0]      sh_wr;
    logic [OW-1:0]      cnt_x;
    logic [PW-1:0]      pos_x;

    // scan compares the element read in the previous cycle
    assign elem_key  = order_key(rdata_reg, element_is_float);
    assign hit       = have_reg && (cur_reg.key < elem_key);
    assign scan_done = hit || (scan_reg == count_reg);
    assign found_pos = hit ? scan_reg - CW'(1) : count_reg;
    always_comb
    begin
        if (!hit && have_reg)
            dup = (elem_key == cur_reg.key);
        else
            dup = prev_valid_reg && (prev_key_reg == cur_reg.key);
    end
    assign full     = (count_reg == CW'(CAPACITY));
    assign idx_x    = XW'(cmd.index);
    assign idx_ok   = idx_x < XW'(count_reg);
    assign res_free = !m_tvalid_reg || m_tready;
    assign sh_wr    = sh_rd_reg + CW'(1);
    assign cnt_x    = OW'(count_reg);
    assign pos_x    = PW'(res_pos_reg);
    assign cmd_pop  = (state_reg == BK_IDLE) && cmd_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_INSERT: state_next = BK_SCAN;
                        OP_READ:   state_next = idx_ok ? BK_READ : BK_RESULT;
                        default:   state_next = BK_RESULT;
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (scan_done)
                begin
                    priority if (dup || full)
                        state_next = BK_RESULT;
                    else if (count_reg > found_pos)
                        state_next = BK_SHIFT;
                    else
                        state_next = BK_PUT;
                end
            end
            BK_SHIFT:  state_next = (left_reg == '0) ? BK_PUT : BK_SHIFT;
            BK_PUT:    state_next = BK_RESULT;
            BK_READ:   state_next = BK_RESULT;
            BK_RESULT: state_next = res_free ? BK_IDLE : BK_RESULT;
            default:   state_next = BK_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next      = count_reg;
        cur_next        = cur_reg;
        scan_next       = scan_reg;
        have_next       = have_reg;
        prev_valid_next = prev_valid_reg;
        prev_key_next   = prev_key_reg;
        pos_next        = pos_reg;
        sh_rd_next      = sh_rd_reg;
        left_next       = left_reg;
        wr_pending_next = wr_pending_reg;
        wr_addr_next    = wr_addr_reg;
        res_status_next = res_status_reg;
        res_elem_next   = res_elem_reg;
        res_pos_next    = res_pos_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        m_elem_next     = m_elem_reg;
        m_pos_next      = m_pos_reg;
        rd_addr         = idx_x[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = pos_reg[AW-1:0];
        wr_data         = cur_reg.value;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next        = cmd;
                    scan_next       = '0;
                    have_next       = 1'b0;
                    prev_valid_next = 1'b0;
                    res_elem_next   = '0;
                    res_pos_next    = '0;
                    unique case (cmd.op)
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = ST_CLEARED;
                        end
                        OP_NAN:    res_status_next = ST_NAN;
                        OP_READ:   res_status_next = idx_ok ? ST_READ_OK : ST_RANGE;
                        OP_INSERT: res_status_next = ST_INSERTED;
                        default:   res_status_next = ST_RANGE;
                    endcase
                end
            end
            BK_SCAN:
            begin
                rd_addr = scan_reg[AW-1:0];
                if (have_reg && !hit)
                begin
                    prev_key_next   = elem_key;
                    prev_valid_next = 1'b1;
                end
                if (scan_done)
                begin
                    pos_next        = found_pos;
                    sh_rd_next      = count_reg - CW'(1);
                    left_next       = count_reg - found_pos;
                    wr_pending_next = 1'b0;
                    priority if (dup)
                    begin
                        res_status_next = ST_DUPLICATE;
                        res_pos_next    = found_pos - CW'(1);
                    end
                    else if (full)
                        res_status_next = ST_FULL;
                    else
                        res_status_next = ST_INSERTED;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                    have_next = 1'b1;
                end
            end
            BK_SHIFT:
            begin
                // move one element up per cycle, top first
                rd_addr = sh_rd_reg[AW-1:0];
                wr_en   = wr_pending_reg;
                wr_addr = wr_addr_reg;
                wr_data = rdata_reg;
                if (left_reg != '0)
                begin
                    sh_rd_next      = sh_rd_reg - CW'(1);
                    left_next       = left_reg - CW'(1);
                    wr_addr_next    = sh_wr[AW-1:0];
                    wr_pending_next = 1'b1;
                end
                else
                    wr_pending_next = 1'b0;
            end
            BK_PUT:
            begin
                wr_en        = 1'b1;
                count_next   = count_reg + CW'(1);
                res_pos_next = pos_reg;
            end
            BK_READ:
            begin
                res_elem_next = rdata_reg;
            end
            BK_RESULT:
            begin
                if (res_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_count_next  = cnt_x[COUNT_OUT_W-1:0];
                    m_elem_next   = res_elem_reg;
                    m_pos_next    = pos_x[POS_OUT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        scan_reg       <= scan_next;
        have_reg       <= have_next;
        prev_valid_reg <= prev_valid_next;
        prev_key_reg   <= prev_key_next;
        pos_reg        <= pos_next;
        sh_rd_reg      <= sh_rd_next;
        left_reg       <= left_next;
        wr_pending_reg <= wr_pending_next;
        wr_addr_reg    <= wr_addr_next;
        res_status_reg <= res_status_next;
        res_elem_reg   <= res_elem_next;
        res_pos_reg    <= res_pos_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
        m_elem_reg     <= m_elem_next;
        m_pos_reg      <= m_pos_next;
    end

    // element memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_pos_reg, m_elem_reg, m_count_reg};

endmodule

// ===== hw/rtl/sorted_unique_set_insert.sv =====
// Sorted unique set of 32-bit values. Top level: mode register, front end,
// command queue and back end. Depends on sus_pkg, sus_front, sus_fifo, sus_back.
//
// Input channel s_*: s_tuser carries the action (clear, insert, read),
// s_tdata the value and the read index. Every input transaction yields
// exactly one output transaction on m_*: m_tuser is the status, m_tdata the
// element count, the element read and the position.
// cfg_wen/cfg_wdata write the compare mode (0 signed integer, 1 single float);
// write it only while the block is idle.
// An insert walks the element memory one entry per cycle: a scan up to the
// insert position, then, unless the value is a duplicate or the set is full,
// a shift of the elements above it and the write of the new value.
// The single read and single write port of the element memory set this.
// Items are processed one at a time; a two-entry queue lets the input side
// keep accepting while one item is in the back end.
// Reset empties the set and selects integer compare; the memory needs no
// clearing pass. If the receiver stalls, the finished result waits in the
// output register and the back end holds its next result until it is taken.
module sorted_unique_set_insert #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // action
    input  logic [39:0] s_tdata,    // value[31:0], index[37:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,    // status
    output logic [47:0] m_tdata,    // element_count[6:0], element[38:7], position[44:39]
    input  logic        cfg_wen,
    input  logic        cfg_wdata   // element_is_float
);
    import sus_pkg::*;

    logic element_is_float_reg;
    logic element_is_float_next;
    logic q_full;
    logic q_push;
    cmd_t q_in;
    logic q_pop;
    cmd_t q_out;
    logic q_not_empty;

    assign element_is_float_next = cfg_wen ? cfg_wdata : element_is_float_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            element_is_float_reg <= 1'b0;
        else
            element_is_float_reg <= element_is_float_next;
    end

    sus_front u_front (
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tuser          (s_tuser),
        .s_tdata          (s_tdata),
        .element_is_float (element_is_float_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (q_in)
    );

    sus_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .dout      (q_out),
        .not_empty (q_not_empty)
    );

    sus_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .element_is_float (element_is_float_reg),
        .cmd_valid        (q_not_empty),
        .cmd              (q_out),
        .cmd_pop          (q_pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tuser          (m_tuser),
        .m_tdata          (m_tdata)
    );

endmodule

// ===== bench/sorted_unique_set_insert_test.sv =====
// self-checking bench for sorted_unique_set_insert: queued set operations, a shadow
// copy of the set that predicts every reply, random idling on both streams
// depends on sus_pkg and the sorted_unique_set_insert rtl
module sorted_unique_set_insert_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sus_pkg::*;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] value;
        logic [5:0]  index;
    } set_cmd_t;

    typedef struct {
        status_t     status;
        logic [6:0]  count;
        logic [31:0] element;
        logic [5:0]  position;
    } set_reply_t;

    localparam int SET_CAPACITY = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = ACT_NOP;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;
    logic [47:0] m_tdata;
    logic        cfg_wen = 1'b0;
    logic        cfg_wdata = 1'b0;

    set_cmd_t    pending_items[$];
    set_reply_t  set_replies_due[$];
    logic [31:0] shadow_set [SET_CAPACITY];
    int          shadow_size = 0;
    logic        float_mode = 1'b0;
    logic        s_taken = 1'b0;
    int          pushed_count = 0;
    int          accepted_count = 0;
    int          failures = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    set_reply_t  due_r;
    set_reply_t  got_r;

    sorted_unique_set_insert #(.CAPACITY(SET_CAPACITY)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),     // action
        .s_tdata   (s_tdata),     // value[31:0], index[37:32]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),     // status
        .m_tdata   (m_tdata),     // element_count[6:0], element[38:7], position[44:39]
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)    // element_is_float
    );

    always #2 clk = ~clk;

    // unsigned key that rises with the value under the current compare mode
    function automatic logic [31:0] sort_key(input logic [31:0] bits);
        logic [31:0] b;
        b = bits;
        if (!float_mode)
            return {~b[31], b[30:0]};
        if (b == 32'h8000_0000)
            b = '0;
        return b[31] ? ~b : {1'b1, b[30:0]};
    endfunction

    function automatic set_reply_t apply_set_op(input logic [1:0] action,
                                                input logic [31:0] value,
                                                input logic [5:0] index);
        set_reply_t  r;
        logic [31:0] key;
        int          pos;
        logic        found;
        r.status   = ST_RANGE;
        r.element  = '0;
        r.position = '0;
        if (action == ACT_CLEAR) begin
            shadow_size = 0;
            r.status = ST_CLEARED;
        end
        else if (action == ACT_INSERT) begin
            if (float_mode && value[30:23] == 8'hFF && value[22:0] != '0) begin
                r.status = ST_NAN;
            end
            else begin
                key = sort_key(value);
                pos = shadow_size;
                found = 1'b0;
                for (int i = 0; i < shadow_size; i++)
                begin
                    if (!found && key < sort_key(shadow_set[i]))
                    begin
                        pos = i;
                        found = 1'b1;
                    end
                end
                if (pos > 0 && sort_key(shadow_set[pos-1]) == key) begin
                    r.status = ST_DUPLICATE;
                    r.position = 6'(pos - 1);
                end
                else if (shadow_size >= SET_CAPACITY) begin
                    r.status = ST_FULL;
                end
                else begin
                    for (int j = shadow_size; j > pos; j--)
                        shadow_set[j] = shadow_set[j-1];
                    shadow_set[pos] = value;
                    shadow_size++;
                    r.status = ST_INSERTED;
                    r.position = 6'(pos);
                end
            end
        end
        else if (action == ACT_READ) begin
            if (int'(index) < shadow_size) begin
                r.status = ST_READ_OK;
                r.element = shadow_set[index];
            end
        end
        r.count = 7'(shadow_size);
        return r;
    endfunction

    // sender: a valid item is held until taken, idles only between transactions
    always @(negedge clk)
    begin
        set_cmd_t c;
        if (rst_n) begin
            if (!s_tvalid || s_taken) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    c = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= c.action;
                    s_tdata <= {2'b00, c.index, c.value};
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            s_taken <= s_tvalid && s_tready;
            if (cfg_wen)
                float_mode = cfg_wdata;
            if (s_tvalid && s_tready) begin
                accepted_count++;
                set_replies_due.push_back(apply_set_op(s_tuser, s_tdata[31:0], s_tdata[37:32]));
            end
            if (m_tvalid && m_tready) begin
                if (set_replies_due.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    failures++;
                end
                else begin
                    due_r = set_replies_due.pop_front();
                    got_r.status   = status_t'(m_tuser);
                    got_r.count    = m_tdata[6:0];
                    got_r.element  = m_tdata[38:7];
                    got_r.position = m_tdata[44:39];
                    if (got_r.status !== due_r.status) begin
                        $error("status: expected %0d, got %0d", due_r.status, m_tuser);
                        failures++;
                    end
                    if (got_r.count !== due_r.count) begin
                        $error("element_count: expected %0d, got %0d", due_r.count, got_r.count);
                        failures++;
                    end
                    if (got_r.element !== due_r.element) begin
                        $error("element: expected %h, got %h", due_r.element, got_r.element);
                        failures++;
                    end
                    if (got_r.position !== due_r.position) begin
                        $error("position: expected %0d, got %0d", due_r.position,
                               got_r.position);
                        failures++;
                    end
                end
            end
        end
    end

    task automatic push_item(input logic [1:0] action, input logic [31:0] value,
                             input logic [5:0] index);
        set_cmd_t c;
        c.action = action;
        c.value = value;
        c.index = index;
        pending_items.push_back(c);
        pushed_count++;
    endtask

    task automatic wait_idle();
        while (accepted_count != pushed_count || set_replies_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_mode(input logic is_float);
        wait_idle();
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= is_float;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 9))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7FFF_FFFF;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h7F80_0000;
                    5: return 32'hFF80_0000;
                    6: return 32'h7FC0_0000;
                    7: return 32'h0000_0001;
                    8: return 32'h3F80_0000;
                    default: return 32'hBF80_0000;
                endcase
            end
            // narrow pools so duplicates show up in both modes
            1: return 32'($urandom_range(0, 15)) - 32'd8;
            2: return {1'($urandom_range(0, 1)), 8'(8'd126 + $urandom_range(0, 3)), 23'd0};
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_sequence(input bit fill_up);
        int n_ins;
        int r;
        if (fill_up || $urandom_range(0, 4) != 0)
            push_item(ACT_CLEAR, $urandom(), 6'($urandom_range(0, 63)));
        if (fill_up)
            n_ins = 90;
        else if ($urandom_range(0, 3) == 0)
            n_ins = $urandom_range(60, 90);
        else
            n_ins = $urandom_range(3, 30);
        for (int i = 0; i < n_ins; i++)
        begin
            push_item(ACT_INSERT, pick_value(), 6'($urandom_range(0, 63)));
            r = $urandom_range(0, 19);
            if (r < 4)
                push_item(ACT_READ, $urandom(), 6'($urandom_range(0, 63)));
            else if (r < 7)
                push_item(ACT_READ, $urandom(), 6'($urandom_range(0, 15)));
            else if (r == 7)
                push_item(ACT_NOP, $urandom(), 6'($urandom_range(0, 63)));
        end
    endtask

    task automatic random_phase(input int n_items, input bit start_full);
        int target;
        target = pushed_count + n_items;
        if (start_full)
            queue_sequence(1'b1);
        while (pushed_count < target) begin
            queue_sequence(1'b0);
            // sometimes let the block drain, often switching the compare with elements held
            if ($urandom_range(0, 2) == 0)
                write_mode(1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 82;
        // integer order: extremes, duplicate, empty and out-of-range reads, unused action
        push_item(ACT_CLEAR, 32'h0, 6'd0);
        push_item(ACT_READ, 32'h0, 6'd0);
        push_item(ACT_INSERT, 32'h8000_0000, 6'd0);
        push_item(ACT_INSERT, 32'h7FFF_FFFF, 6'd63);
        push_item(ACT_INSERT, 32'h0000_0000, 6'd0);
        push_item(ACT_INSERT, 32'h0000_0000, 6'd0);
        push_item(ACT_INSERT, 32'hFFFF_FFFF, 6'd0);
        push_item(ACT_READ, 32'hFFFF_FFFF, 6'd0);
        push_item(ACT_READ, 32'h0, 6'd3);
        push_item(ACT_READ, 32'h0, 6'd4);
        push_item(ACT_READ, 32'h0, 6'd63);
        push_item(ACT_NOP, 32'hFFFF_FFFF, 6'd63);
        write_mode(1'b1);
        // float order: signed zeros, NaNs, infinities, denormal
        push_item(ACT_CLEAR, 32'hFFFF_FFFF, 6'd63);
        push_item(ACT_INSERT, 32'h0000_0000, 6'd0);
        push_item(ACT_INSERT, 32'h8000_0000, 6'd0);
        push_item(ACT_INSERT, 32'h7FC0_0000, 6'd0);
        push_item(ACT_INSERT, 32'hFFFF_FFFF, 6'd0);
        push_item(ACT_INSERT, 32'h7F80_0000, 6'd0);
        push_item(ACT_INSERT, 32'hFF80_0000, 6'd0);
        push_item(ACT_INSERT, 32'h0000_0001, 6'd0);
        push_item(ACT_INSERT, 32'hBF80_0000, 6'd0);
        push_item(ACT_INSERT, 32'h3F80_0000, 6'd0);
        push_item(ACT_READ, 32'h0, 6'd0);
        push_item(ACT_READ, 32'h0, 6'd5);
        wait_idle();

        random_phase(170, 1'b0);

        send_idle_pct = 82;
        recv_idle_pct = 10;
        write_mode(1'b0);
        random_phase(170, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mode(1'b1);
        random_phase(170, 1'b1);

        wait_idle();
        repeat (20) @(posedge clk);
        if (failures == 0 && set_replies_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sus_pkg.sv
hw/rtl/sus_front.sv
hw/rtl/sus_fifo.sv
hw/rtl/sus_back.sv
hw/rtl/sorted_unique_set_insert.sv
bench/sorted_unique_set_insert_test.sv
